FILE: hw/rtl/normal_matrix_3x3_unit_macros.svh
// assertion macros shared by the normal matrix unit
// no dependencies; expects clock and reset in the including scope
`ifndef NORMAL_MATRIX_3X3_UNIT_MACROS_SVH
`define NORMAL_MATRIX_3X3_UNIT_MACROS_SVH

// same-cycle implication
`define NM3_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("normal matrix unit: assertion failed");

// next-cycle implication
`define NM3_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("normal matrix unit: assertion failed");

`endif

FILE: hw/rtl/nm3_pkg.sv
// types and constants of the normal matrix unit
// no dependencies
package nm3_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PW        = 64;                   // element product
   localparam int CW        = 65;                   // cofactor, signed
   localparam int DW        = 98;                   // determinant, signed
   localparam int NW        = 64 + 2*FRAC_BITS + 2; // divider dividend and divisor
   localparam int QB        = 33;                   // quotient bits below overflow
   localparam int FRONT_LAT = 6;
   localparam int LANE_LAT  = QB + 2;
   localparam int TOT_LAT   = FRONT_LAT + LANE_LAT;
   localparam logic [31:0] THR_RESET = 32'd281;
   localparam logic [31:0] FIX_ONE   = 32'(64'd1 << FRAC_BITS);

   typedef struct packed {
      logic signed [31:0] w_r0c0;
      logic signed [31:0] w_r0c1;
      logic signed [31:0] w_r0c2;
      logic signed [31:0] w_r1c0;
      logic signed [31:0] w_r1c1;
      logic signed [31:0] w_r1c2;
      logic signed [31:0] w_r2c0;
      logic signed [31:0] w_r2c1;
      logic signed [31:0] w_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] normal_0;
      logic signed [31:0] normal_1;
      logic signed [31:0] normal_2;
      logic signed [31:0] normal_3;
      logic signed [31:0] normal_4;
      logic signed [31:0] normal_5;
      logic signed [31:0] normal_6;
      logic signed [31:0] normal_7;
      logic signed [31:0] normal_8;
      logic               singular;
   } rsp_type;

   typedef struct packed {
      logic [NW-1:0] num;
      logic          neg;
   } lane_in_type;

endpackage

FILE: hw/rtl/nm3_front.sv
// cofactors, determinant and singular decision, six register stages
// depends on nm3_pkg
module nm3_front (
   input  logic                          clock,
   input  logic                          enable,
   input  nm3_pkg::req_type              req_data,
   input  logic [31:0]                   threshold,
   output nm3_pkg::lane_in_type [8:0]    lane_in,
   output logic [nm3_pkg::NW-1:0]        den,
   output logic                          singular
);
   import nm3_pkg::*;

   // element index pairs, two products per cofactor
   localparam int PA [36] = '{4,8, 5,7, 2,7, 1,8, 1,5, 2,4, 5,6, 3,8, 0,8,
                              2,6, 2,3, 0,5, 3,7, 4,6, 1,6, 0,7, 0,4, 1,3};

   logic signed [31:0] a [9];
   logic signed [PW-1:0] p_ff [18];
   logic signed [CW-1:0] cof_ff [9];
   logic signed [CW-1:0] cof2_ff [9];
   logic signed [CW-1:0] cof3_ff [9];
   logic signed [CW-1:0] cof4_ff [9];
   logic signed [31:0] a1_ff [3];
   logic signed [31:0] a2_ff [3];
   logic signed [64:0] lo_ff [3];
   logic signed [64:0] hi_ff [3];
   logic signed [DW-1:0] term_ff [3];
   logic signed [DW-1:0] det_ff;
   logic [DW-2:0] ad;
   logic [63:0] ac [9];
   nm3_pkg::lane_in_type [8:0] lane_ff;
   logic [NW-1:0] den_ff;
   logic sing_ff;

   assign a = '{req_data.w_r0c0, req_data.w_r0c1, req_data.w_r0c2,
                req_data.w_r1c0, req_data.w_r1c1, req_data.w_r1c2,
                req_data.w_r2c0, req_data.w_r2c1, req_data.w_r2c2};

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < 18; j++) begin
            p_ff[j] <= PW'(a[PA[2*j]] * a[PA[2*j+1]]);
         end
         a1_ff <= '{a[0], a[1], a[2]};
      end
   end

   assign ad = det_ff[DW-1] ? (DW-1)'(-det_ff) : det_ff[DW-2:0];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         ac[k] = cof4_ff[k][CW-1] ? 64'(-cof4_ff[k]) : cof4_ff[k][63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 9; k++) begin
            cof_ff[k] <= CW'(p_ff[2*k]) - CW'(p_ff[2*k+1]);
         end
         a2_ff <= a1_ff;
         cof2_ff <= cof_ff;
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= 65'(a2_ff[i] * $signed({1'b0, cof_ff[3*i][31:0]}));
            hi_ff[i] <= 65'(a2_ff[i] * $signed(cof_ff[3*i][64:32]));
         end
         cof3_ff <= cof2_ff;
         for (int i = 0; i < 3; i++) begin
            term_ff[i] <= DW'(lo_ff[i]) + (DW'(hi_ff[i]) <<< 32);
         end
         cof4_ff <= cof3_ff;
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
         for (int k = 0; k < 9; k++) begin
            lane_ff[k].num <= (NW'(ac[k]) << (2*FRAC_BITS + 1)) + NW'(ad);
            lane_ff[k].neg <= cof4_ff[k][CW-1] ^ det_ff[DW-1];
         end
         den_ff  <= NW'({ad, 1'b0});
         sing_ff <= (ad == '0) || (ad < (DW-1)'(threshold));
      end
   end

   assign lane_in  = lane_ff;
   assign den      = den_ff;
   assign singular = sing_ff;

endmodule

FILE: hw/rtl/nm3_div_lane.sv
// one divider lane: restoring division one quotient bit per stage, rounding, saturation
// depends on nm3_pkg
module nm3_div_lane (
   input  logic                   clock,
   input  logic                   enable,
   input  nm3_pkg::lane_in_type   lane_in,
   input  logic [nm3_pkg::NW-1:0] den,
   output logic [31:0]            result
);
   import nm3_pkg::*;

   localparam int WW = NW + QB + 1;

   logic [NW-1:0] rem_ff [QB+1];
   logic [NW-1:0] den_ff [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic          neg_ff [QB+1];
   logic          ovf_ff [QB+1];
   logic [31:0]   result_ff;
   logic [QB-1:0] q;

   for (genvar s = 0; s <= QB; s++) begin : g_stage
      logic [NW-1:0] cur_rem;
      logic [NW-1:0] cur_den;
      logic [QB-1:0] cur_quo;
      logic          cur_neg;
      logic          cur_ovf;
      logic [WW:0]   diff;
      logic          take;
      if (s == 0) begin : g_first
         assign cur_rem = lane_in.num;
         assign cur_den = den;
         assign cur_quo = '0;
         assign cur_neg = lane_in.neg;
         assign cur_ovf = 1'b0;
      end else begin : g_next
         assign cur_rem = rem_ff[s-1];
         assign cur_den = den_ff[s-1];
         assign cur_quo = quo_ff[s-1];
         assign cur_neg = neg_ff[s-1];
         assign cur_ovf = ovf_ff[s-1];
      end
      assign diff = {1'b0, WW'(cur_rem)} - ({1'b0, WW'(cur_den)} << (QB - s));
      assign take = !diff[WW];
      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[s] <= cur_den;
            neg_ff[s] <= cur_neg;
            if (s == 0) begin
               rem_ff[s] <= cur_rem;
               quo_ff[s] <= '0;
               ovf_ff[s] <= take;
            end else begin
               rem_ff[s] <= take ? diff[NW-1:0] : cur_rem;
               quo_ff[s] <= {cur_quo[QB-2:0], take};
               ovf_ff[s] <= cur_ovf;
            end
         end
      end
   end

   assign q = quo_ff[QB];

   always_ff @(posedge clock) begin
      if (enable) begin
         if (neg_ff[QB]) begin
            if (ovf_ff[QB] || q > QB'(33'h080000000)) begin
               result_ff <= 32'h80000000;
            end else begin
               result_ff <= 32'(-q);
            end
         end else begin
            if (ovf_ff[QB] || q > QB'(33'h07FFFFFFF)) begin
               result_ff <= 32'h7FFFFFFF;
            end else begin
               result_ff <= q[31:0];
            end
         end
      end
   end

   assign result = result_ff;

endmodule

FILE: hw/rtl/normal_matrix_3x3_unit.sv
// Normal matrix unit: transposed inverse of a 3x3 Q16.16 matrix, column-major.
// Depends on nm3_pkg, nm3_front, nm3_div_lane and the assertion macro header.
//
// Usage:
//   req channel (req_valid, req_stall, req_data) carries one 3x3 matrix per
//   transaction; rsp channel (rsp_valid, rsp_stall, rsp_data) returns the nine
//   normal matrix elements and the singular flag, one transaction per input.
//   csr channel (csr_valid, csr_ready, csr_data) writes the singular threshold;
//   csr_ready is always high. Write it only while the unit is empty.
// Throughput: one matrix per cycle unless stalled. Nine divider lanes run side by side,
//   one per cofactor, each resolving one quotient bit per pipeline stage.
// Pipeline: 42 register stages between the accepting edge and rsp_valid
//   (6 cofactor/determinant, 35 divider, one merge register).
// Reset: synchronous, active high; empties the pipeline, threshold returns to 281.
// Stall: while rsp_stall holds a waiting result, the whole pipeline freezes
//   and req_stall is raised; results are never lost or repeated.
`include "normal_matrix_3x3_unit_macros.svh"
module normal_matrix_3x3_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nm3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nm3_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import nm3_pkg::*;

   logic                 enable;
   logic [31:0]          threshold_ff;
   logic [TOT_LAT-1:0]   vld_ff;
   logic [LANE_LAT-1:0]  sing_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   lane_in_type [8:0]    lane_in;
   logic [NW-1:0]        den;
   logic                 front_sing;
   logic [31:0]          lane_out [9];

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_valid) begin
         threshold_ff <= csr_data;
      end
   end

   nm3_front u_front (
      .clock     (clock),
      .enable    (enable),
      .req_data  (req_data),
      .threshold (threshold_ff),
      .lane_in   (lane_in),
      .den       (den),
      .singular  (front_sing)
   );

   for (genvar k = 0; k < 9; k++) begin : g_lane
      nm3_div_lane u_lane (
         .clock   (clock),
         .enable  (enable),
         .lane_in (lane_in[k]),
         .den     (den),
         .result  (lane_out[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff       <= {vld_ff[TOT_LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[TOT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sing_ff <= {sing_ff[LANE_LAT-2:0], front_sing};
         if (sing_ff[LANE_LAT-1]) begin
            rsp_ff <= '{FIX_ONE, 32'd0, 32'd0, 32'd0, FIX_ONE, 32'd0,
                        32'd0, 32'd0, FIX_ONE, 1'b1};
         end else begin
            rsp_ff <= '{lane_out[0], lane_out[1], lane_out[2], lane_out[3],
                        lane_out[4], lane_out[5], lane_out[6], lane_out[7],
                        lane_out[8], 1'b0};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `NM3_ASSERT_NOW(a_identity, rsp_valid_ff && rsp_ff.singular, rsp_ff.normal_0 == FIX_ONE && rsp_ff.normal_1 == 32'd0 && rsp_ff.normal_8 == FIX_ONE)
   `NM3_ASSERT_NOW(a_empty_accepts, !rsp_valid_ff, !req_stall)
   `NM3_ASSERT_NEXT(a_pipe_drains, enable && vld_ff[TOT_LAT-1], rsp_valid_ff)
   `NM3_ASSERT_NEXT(a_csr_write, csr_valid && csr_ready, threshold_ff == $past(csr_data))

endmodule

FILE: tb/tb_normal_matrix_3x3_unit.sv
// self-checking testbench for normal_matrix_3x3_unit: directed table, then random matrices
// depends on nm3_pkg and the unit; expectations come from the table or an exact 128-bit predictor
module tb_normal_matrix_3x3_unit;
   import nm3_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_PER_PHASE = 150;
   localparam logic signed [31:0] ONE = 32'sd65536;

   typedef struct {
      req_type mat;
      bit      known;
      rsp_type want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   rsp_type       pending_normals[$];
   logic [31:0]   threshold_copy = THR_RESET;
   int            mismatch_count = 0;
   int            idle_cycles = 0;
   int            stall_left = 0;
   bit            quiet_rsp = 1'b0;
   bit            quiet_req = 1'b0;
   table_row_type directed[$];

   normal_matrix_3x3_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] scaled_quotient(logic signed [127:0] c,
                                                   logic signed [127:0] d);
      logic [127:0] ac, ad, q;
      logic         neg;
      ac  = (c < 0) ? -c : c;
      ad  = (d < 0) ? -d : d;
      q   = ((ac << (2*FRAC_BITS + 1)) + ad) / (ad << 1);
      neg = (c < 0) != (d < 0);
      if (neg)
         return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
   endfunction

   function automatic rsp_type normal_of(req_type m, logic [31:0] thr);
      logic signed [127:0] a[9];
      logic signed [127:0] cof[9];
      logic signed [127:0] det;
      logic [127:0]        mag;
      rsp_type             r;
      logic [31:0]         v[9];
      a[0] = m.w_r0c0; a[1] = m.w_r0c1; a[2] = m.w_r0c2;
      a[3] = m.w_r1c0; a[4] = m.w_r1c1; a[5] = m.w_r1c2;
      a[6] = m.w_r2c0; a[7] = m.w_r2c1; a[8] = m.w_r2c2;
      cof[0] = a[4]*a[8] - a[5]*a[7];
      cof[1] = a[2]*a[7] - a[1]*a[8];
      cof[2] = a[1]*a[5] - a[2]*a[4];
      cof[3] = a[5]*a[6] - a[3]*a[8];
      cof[4] = a[0]*a[8] - a[2]*a[6];
      cof[5] = a[2]*a[3] - a[0]*a[5];
      cof[6] = a[3]*a[7] - a[4]*a[6];
      cof[7] = a[1]*a[6] - a[0]*a[7];
      cof[8] = a[0]*a[4] - a[1]*a[3];
      det = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
      mag = (det < 0) ? -det : det;
      r = '0;
      if (mag == 0 || mag < {96'd0, thr}) begin
         r.normal_0 = FIX_ONE;
         r.normal_4 = FIX_ONE;
         r.normal_8 = FIX_ONE;
         r.singular = 1'b1;
         return r;
      end
      for (int k = 0; k < 9; k++) v[k] = scaled_quotient(cof[k], det);
      r.normal_0 = v[0]; r.normal_1 = v[1]; r.normal_2 = v[2];
      r.normal_3 = v[3]; r.normal_4 = v[4]; r.normal_5 = v[5];
      r.normal_6 = v[6]; r.normal_7 = v[7]; r.normal_8 = v[8];
      return r;
   endfunction

   function automatic req_type make_matrix(logic signed [31:0] e0, e1, e2, e3, e4,
                                           e5, e6, e7, e8);
      return '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
   endfunction

   function automatic rsp_type diagonal_normals(logic signed [31:0] d0, d4, d8,
                                                logic sing);
      rsp_type r;
      r = '0;
      r.normal_0 = d0;
      r.normal_4 = d4;
      r.normal_8 = d8;
      r.singular = sing;
      return r;
   endfunction

   function automatic logic signed [31:0] random_element(int mode);
      case (mode)
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
         2:       return $signed($urandom_range(0, 128)) - 32'sd64;
         default: return $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      int      mode, sel;
      sel  = $urandom_range(0, 9);
      mode = (sel < 3) ? 0 : (sel < 6) ? 1 : (sel < 8) ? 2 : 3;
      m = '{random_element(mode), random_element(mode), random_element(mode),
            random_element(mode), random_element(mode), random_element(mode),
            random_element(mode), random_element(mode), random_element(mode)};
      // nearly dependent rows to land around the threshold
      if (sel == 9) begin
         m.w_r2c0 = m.w_r0c0 + m.w_r1c0 + random_element(2);
         m.w_r2c1 = m.w_r0c1 + m.w_r1c1 + random_element(2);
         m.w_r2c2 = m.w_r0c2 + m.w_r1c2 + random_element(2);
      end
      return m;
   endfunction

   task automatic add_row(req_type m, bit known, rsp_type want);
      table_row_type row;
      row.mat   = m;
      row.known = known;
      row.want  = want;
      directed  = {directed, row};
   endtask

   task automatic send_matrix(req_type m, bit known, rsp_type want);
      int      gap;
      rsp_type want_rsp;
      if (!quiet_req && $urandom_range(0, 39) == 0) quiet_req = 1'b1;
      else if (quiet_req && $urandom_range(0, 19) == 0) quiet_req = 1'b0;
      gap = quiet_req ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (req_stall);
      want_rsp = known ? want : normal_of(m, threshold_copy);
      pending_normals = {pending_normals, want_rsp};
   endtask

   task automatic drain_and_write_threshold(logic [31:0] value);
      @(negedge clock) req_valid <= 1'b0;
      wait (pending_normals.size() == 0);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      threshold_copy = value;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && !rsp_stall) begin
         if (!quiet_rsp && $urandom_range(0, 39) == 0) quiet_rsp = 1'b1;
         else if (quiet_rsp && $urandom_range(0, 19) == 0) quiet_rsp = 1'b0;
         stall_left = quiet_rsp ? 0 : $urandom_range(0, 14);
         if (pending_normals.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction %h", rsp_data);
         end else begin
            want = pending_normals.pop_front();
            for (int k = 0; k < 10; k++) begin
               if ((k < 9 && rsp_data[288 - 32*k -: 32] !== want[288 - 32*k -: 32]) ||
                   (k == 9 && rsp_data.singular !== want.singular)) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     if (k < 9)
                        $display("normal_%0d: expected %h got %h", k,
                                 want[288 - 32*k -: 32], rsp_data[288 - 32*k -: 32]);
                     else
                        $display("singular: expected %b got %b", want.singular,
                                 rsp_data.singular);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [31:0] thresholds[5];
      thresholds = '{32'd0, 32'hFFFF_FFFF, $urandom, THR_RESET, 32'd1};
      add_row(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
              diagonal_normals(ONE, ONE, ONE, 1'b0));
      add_row(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              diagonal_normals(ONE, ONE, ONE, 1'b1));
      add_row(make_matrix('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                          '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1), 1,
              diagonal_normals(ONE, ONE, ONE, 1'b1));
      add_row(make_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1,
              diagonal_normals(ONE, ONE, ONE, 1'b1));
      add_row(make_matrix(2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE), 1,
              diagonal_normals(32'sd32768, 32'sd32768, 32'sd32768, 1'b0));
      add_row(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, 1), 1,
              diagonal_normals(ONE, ONE, 32'sh7FFF_FFFF, 1'b0));
      add_row(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, -1), 1,
              diagonal_normals(ONE, ONE, 32'sh8000_0000, 1'b0));
      add_row(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
              diagonal_normals(ONE, ONE, ONE, 1'b1));
      add_row(make_matrix(16, 0, 0, 0, 17, 0, 0, 0, 1), 1,
              diagonal_normals(ONE, ONE, ONE, 1'b1));
      add_row(make_matrix(17, 0, 0, 0, 17, 0, 0, 0, 1), 0, '0);
      add_row(make_matrix(32'sh7FFF_FFFF, 0, 0, 0, 32'sh8000_0000, 0,
                          0, 0, 32'sh7FFF_FFFF), 0, '0);
      add_row(make_matrix(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE), 0, '0);
      add_row(make_matrix(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE,
                          6*ONE, 0), 0, '0);
      add_row(make_matrix(32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1,
                          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 3,
                          32'sh7FFF_FFFF), 0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed[i]) send_matrix(directed[i].mat, directed[i].known, directed[i].want);
      for (int p = 0; p < 5; p++) begin
         drain_and_write_threshold(thresholds[p]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2) begin
               @(negedge clock) req_valid <= 1'b0;
               wait (pending_normals.size() == 0);
            end
            send_matrix(random_matrix(), 1'b0, '0);
         end
      end
      @(negedge clock) req_valid <= 1'b0;
      wait (pending_normals.size() == 0);
      repeat (TOT_LAT + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_normals.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
